// ----- hdl/mrs_pkg.sv -----
// shared types and constants for the running statistics unit
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int CHANNELS_DEF   = 16;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int WINDOW_RESET   = 16;
  localparam int DIV_W          = 64;
  localparam int DVS_W          = 32;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MDIV, S_MUL, S_M2, S_WR, S_PDIV, S_SDIV,
    S_SQRT, S_WIN, S_WADR, S_WDAT, S_WDIV, S_FIN
  } state_t;

  typedef struct packed {
    logic [31:0]        count;
    logic signed [31:0] mean;
    logic [63:0]        m2;
    logic signed [31:0] minv;
    logic signed [31:0] maxv;
  } stat_rec_t;

  localparam int REC_W = $bits(stat_rec_t);

endpackage

// ----- hdl/mrs_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mrs_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mrs_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mrs_pkg::DIV_W-1:0] dividend,
  input  logic [mrs_pkg::DVS_W-1:0] divisor,
  output logic [mrs_pkg::DIV_W-1:0] quotient,
  output logic                     done
);

  localparam int CW = $clog2(mrs_pkg::DIV_W + 1);

  logic [mrs_pkg::DVS_W-1:0] rem;
  logic [mrs_pkg::DVS_W-1:0] dvs;
  logic [CW-1:0]             steps;
  logic                      busy;
  logic [mrs_pkg::DVS_W:0]   trial;

  assign trial = {rem, quotient[mrs_pkg::DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CW'(mrs_pkg::DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= mrs_pkg::DVS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[mrs_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[mrs_pkg::DVS_W-1:0];
        quotient <= {quotient[mrs_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- hdl/multichannel_running_statistics_unit.sv -----
// top level of the multichannel running statistics unit
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in        request    in_valid / in_stall  func, channel, sample
// out       result     out_valid / out_stall statistics of the addressed channel
// cfg       write      cfg_wr_en            cfg_wr_data (window size)
//
// one request at a time; an add runs the mean divide, a 33-step serial multiply,
// both variance divides, a 32-step square root and a walk over the window with the
// window average divide, all divides on the shared divider; a query runs the same
// minus mean divide and multiply; below two samples, fewer divides and no square root
// rst is synchronous; all stores read as empty after reset, no clearing pass
// a finished result waits in the output register while the next request is taken
module multichannel_running_statistics_unit #(
  parameter int CHANNELS   = mrs_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX = mrs_pkg::WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [3:0]         channel,
  input  logic signed [31:0] sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        sample_total,
  output logic signed [31:0] mean_value,
  output logic [63:0]        population_variance,
  output logic [63:0]        sample_variance,
  output logic [31:0]        std_deviation,
  output logic signed [31:0] minimum,
  output logic signed [31:0] maximum,
  output logic signed [31:0] window_average,
  output logic               saturated,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int SW = 32 + FW;
  localparam int SQ_STEPS = 32;

  // clamp a window size to the supported range
  function automatic logic [FW-1:0] eff_win(input logic [6:0] ws);
    logic [31:0] w;
    w = 32'(ws);
    if (w == 32'd0) begin
      return FW'(1);
    end else if (w > 32'(WINDOW_MAX)) begin
      return FW'(WINDOW_MAX);
    end else begin
      return FW'(w);
    end
  endfunction

  function automatic logic [32:0] e_mag(input logic [31:0] xv, input logic [31:0] mv);
    logic [32:0] e;
    e = {xv[31], xv} - {mv[31], mv};
    return e[32] ? (33'd0 - e) : e;
  endfunction

  mrs_pkg::state_t state, state_next;

  // request and working registers
  logic [1:0]         func_r;
  logic [3:0]         ch_r;
  logic signed [31:0] x_r;
  logic               oor;
  mrs_pkg::stat_rec_t rec;
  logic               ev;
  logic [PW-1:0]      head_r;
  logic [FW-1:0]      fill_r;
  logic               dneg;
  logic [32:0]        dmag;
  logic [65:0]        mcand;
  logic [32:0]        mer;
  logic [65:0]        acc;
  logic [6:0]         step;
  logic [63:0]        sq_v;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [63:0]        pvar;
  logic [63:0]        svar;
  logic signed [31:0] wavg;
  logic [SW-1:0]      sum;
  logic [PW-1:0]      pos;
  logic [FW-1:0]      walk;

  // per-channel flags and ring pointers
  logic               chan_valid [CHANNELS];
  logic               ext_valid  [CHANNELS];
  logic [PW-1:0]      head_mem   [CHANNELS];
  logic [FW-1:0]      fill_mem   [CHANNELS];
  logic [6:0]         window_size;
  logic [FW-1:0]      eff_cur;
  logic [FW-1:0]      eff_new;

  // shared divider
  logic               div_start;
  logic [63:0]        div_a;
  logic [31:0]        div_b;
  logic [63:0]        div_q;
  logic               div_done;

  // memories
  logic [CW-1:0]      ch_idx;
  logic               stat_we;
  logic [CW-1:0]      stat_raddr;
  logic [mrs_pkg::REC_W-1:0] stat_rdata;
  logic               ring_we;
  logic [CW+PW-1:0]   ring_waddr;
  logic [CW+PW-1:0]   ring_raddr;
  logic [31:0]        ring_rdata;

  // combinational helpers
  logic               accept;
  logic               out_free;
  mrs_pkg::stat_rec_t rec_rd;
  logic [PW-1:0]      head_rd;
  logic [FW-1:0]      fill_rd;
  logic [32:0]        d_rd;
  logic [32:0]        dmag_rd;
  logic [33:0]        mean_sum;
  logic [31:0]        mean_n;
  logic [64:0]        m2_sum;
  logic [PW-1:0]      pos_dec;
  logic [SW-1:0]      sum_n;
  logic [SW-1:0]      sum_mag;
  logic [63:0]        sq_try;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign ch_idx   = CW'(ch_r);
  assign eff_cur  = eff_win(window_size);
  assign eff_new  = eff_win(cfg_wr_data);

  // record as read, gated by the channel valid flag and shaped by the operation
  always_comb begin
    rec_rd  = chan_valid[ch_idx] ? mrs_pkg::stat_rec_t'(stat_rdata) : '0;
    head_rd = head_mem[ch_idx];
    fill_rd = fill_mem[ch_idx];
    if (oor) begin
      rec_rd  = '0;
      fill_rd = '0;
    end else if (func_r == mrs_pkg::FUNC_ADD) begin
      rec_rd.count = (rec_rd.count == '1) ? rec_rd.count : rec_rd.count + 32'd1;
    end else if (func_r == mrs_pkg::FUNC_CLEAR) begin
      rec_rd.count = '0;
      rec_rd.mean  = '0;
      rec_rd.m2    = '0;
      head_rd      = '0;
      fill_rd      = '0;
    end
  end

  // deviation from the old mean
  assign d_rd     = {x_r[31], x_r} - {rec_rd.mean[31], rec_rd.mean};
  assign dmag_rd  = d_rd[32] ? (33'd0 - d_rd) : d_rd;

  assign mean_sum = {{2{rec.mean[31]}}, rec.mean}
                  + (dneg ? (34'd0 - {1'b0, div_q[32:0]}) : {1'b0, div_q[32:0]});
  assign mean_n   = mean_sum[31:0];
  assign m2_sum   = {1'b0, rec.m2} + {1'b0, acc[63:0]};
  assign pos_dec  = (pos == '0) ? PW'(WINDOW_MAX - 1) : pos - 1'b1;
  assign sum_n    = sum + {{(SW-32){ring_rdata[31]}}, ring_rdata};
  assign sum_mag  = sum_n[SW-1] ? ('0 - sum_n) : sum_n;
  assign sq_try   = sq_res + sq_bit;

  assign stat_raddr = (state == mrs_pkg::S_IDLE) ? CW'(channel) : ch_idx;
  assign stat_we    = (state == mrs_pkg::S_WR);
  assign ring_we    = (state == mrs_pkg::S_M2);
  assign ring_waddr = {ch_idx, head_r};
  assign ring_raddr = {ch_idx, pos_dec};

  mrs_ram #(
    .WIDTH (mrs_pkg::REC_W),
    .DEPTH (2 ** CW)
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (ch_idx),
    .wdata (rec),
    .raddr (stat_raddr),
    .rdata (stat_rdata)
  );

  mrs_ram #(
    .WIDTH (32),
    .DEPTH ((2 ** CW) << PW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (x_r),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  mrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and input stall
  always_comb begin
    state_next = state;
    in_stall   = (state != mrs_pkg::S_IDLE);
    unique case (state)
      mrs_pkg::S_IDLE: begin
        if (in_valid) state_next = mrs_pkg::S_RD;
      end
      mrs_pkg::S_RD: begin
        if (oor) begin
          state_next = mrs_pkg::S_FIN;
        end else if (func_r == mrs_pkg::FUNC_ADD) begin
          state_next = mrs_pkg::S_MDIV;
        end else begin
          state_next = mrs_pkg::S_WR;
        end
      end
      mrs_pkg::S_MDIV: if (div_done) state_next = mrs_pkg::S_MUL;
      mrs_pkg::S_MUL:  if (step == 7'd1) state_next = mrs_pkg::S_M2;
      mrs_pkg::S_M2:   state_next = mrs_pkg::S_WR;
      mrs_pkg::S_WR: begin
        state_next = (rec.count != '0) ? mrs_pkg::S_PDIV : mrs_pkg::S_WIN;
      end
      mrs_pkg::S_PDIV: begin
        if (div_done) begin
          state_next = (rec.count >= 32'd2) ? mrs_pkg::S_SDIV : mrs_pkg::S_WIN;
        end
      end
      mrs_pkg::S_SDIV: if (div_done) state_next = mrs_pkg::S_SQRT;
      mrs_pkg::S_SQRT: if (step == 7'd1) state_next = mrs_pkg::S_WIN;
      mrs_pkg::S_WIN: begin
        state_next = (fill_r == '0) ? mrs_pkg::S_FIN : mrs_pkg::S_WADR;
      end
      mrs_pkg::S_WADR: state_next = mrs_pkg::S_WDAT;
      mrs_pkg::S_WDAT: begin
        state_next = (walk + 1'b1 == fill_r) ? mrs_pkg::S_WDIV : mrs_pkg::S_WADR;
      end
      mrs_pkg::S_WDIV: if (div_done) state_next = mrs_pkg::S_FIN;
      mrs_pkg::S_FIN:  if (out_free) state_next = mrs_pkg::S_IDLE;
      default:         state_next = mrs_pkg::S_IDLE;
    endcase
  end

  // divider start pulses
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == mrs_pkg::S_RD && !oor && func_r == mrs_pkg::FUNC_ADD)
                || (state == mrs_pkg::S_WR && rec.count != '0)
                || (state == mrs_pkg::S_PDIV && div_done && rec.count >= 32'd2)
                || (state == mrs_pkg::S_WDAT && walk + 1'b1 == fill_r);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mrs_pkg::S_IDLE: begin
        if (accept) begin
          func_r <= func;
          ch_r   <= channel;
          x_r    <= sample;
          oor    <= (32'(channel) >= 32'(CHANNELS));
        end
      end
      mrs_pkg::S_RD: begin
        rec    <= rec_rd;
        ev     <= ext_valid[ch_idx];
        head_r <= head_rd;
        fill_r <= fill_rd;
        pvar   <= '0;
        svar   <= '0;
        sq_res <= '0;
        wavg   <= '0;
        // mean divide is issued as the record arrives
        if (!oor && func_r == mrs_pkg::FUNC_ADD) begin
          div_a <= 64'(dmag_rd);
          div_b <= rec_rd.count;
          dneg  <= d_rd[32];
          dmag  <= dmag_rd;
        end
      end
      mrs_pkg::S_MDIV: begin
        if (div_done) begin
          rec.mean <= mean_n;
          mcand    <= {33'd0, dmag};
          mer      <= 33'(e_mag(x_r, mean_n));
          acc      <= '0;
          step     <= 7'd33;
        end
      end
      mrs_pkg::S_MUL: begin
        if (mer[0]) acc <= acc + mcand;
        mcand <= {mcand[64:0], 1'b0};
        mer   <= {1'b0, mer[32:1]};
        step  <= step - 7'd1;
      end
      mrs_pkg::S_M2: begin
        rec.m2 <= m2_sum[64] ? '1 : m2_sum[63:0];
        if (!ev || x_r < rec.minv) rec.minv <= x_r;
        if (!ev || x_r > rec.maxv) rec.maxv <= x_r;
        ev     <= 1'b1;
        head_r <= (head_r == PW'(WINDOW_MAX - 1)) ? '0 : head_r + 1'b1;
        if (fill_r < eff_cur) begin
          fill_r <= fill_r + 1'b1;
        end else begin
          fill_r <= eff_cur;
        end
      end
      mrs_pkg::S_WR: begin
        if (rec.count != '0) begin
          div_a <= rec.m2;
          div_b <= rec.count;
        end
      end
      mrs_pkg::S_PDIV: begin
        if (div_done) begin
          pvar <= div_q;
          if (rec.count >= 32'd2) begin
            div_a <= rec.m2;
            div_b <= rec.count - 32'd1;
          end
        end
      end
      mrs_pkg::S_SDIV: begin
        if (div_done) begin
          svar   <= div_q;
          sq_v   <= div_q;
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          step   <= 7'(SQ_STEPS);
        end
      end
      mrs_pkg::S_SQRT: begin
        // one result bit per step, remainder kept in sq_v
        if (sq_v >= sq_try) begin
          sq_v   <= sq_v - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        step   <= step - 7'd1;
      end
      mrs_pkg::S_WIN: begin
        sum  <= '0;
        walk <= '0;
        pos  <= head_r;
      end
      mrs_pkg::S_WADR: begin
        pos <= pos_dec;
      end
      mrs_pkg::S_WDAT: begin
        sum  <= sum_n;
        walk <= walk + 1'b1;
        if (walk + 1'b1 == fill_r) begin
          div_a <= 64'(sum_mag);
          div_b <= 32'(fill_r);
        end
      end
      mrs_pkg::S_WDIV: begin
        if (div_done) begin
          wavg <= sum[SW-1] ? (32'd0 - div_q[31:0]) : div_q[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // per-channel flags, ring pointers and window size
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 7'(mrs_pkg::WINDOW_RESET);
      for (int i = 0; i < CHANNELS; i++) begin
        chan_valid[i] <= 1'b0;
        ext_valid[i]  <= 1'b0;
        head_mem[i]   <= '0;
        fill_mem[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
        for (int i = 0; i < CHANNELS; i++) begin
          if (fill_mem[i] > eff_new) fill_mem[i] <= eff_new;
        end
      end
      if (state == mrs_pkg::S_WR) begin
        chan_valid[ch_idx] <= 1'b1;
        ext_valid[ch_idx]  <= ev;
        head_mem[ch_idx]   <= head_r;
        fill_mem[ch_idx]   <= fill_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mrs_pkg::S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mrs_pkg::S_FIN && out_free) begin
      sample_total        <= rec.count;
      mean_value          <= (rec.count != '0) ? rec.mean : '0;
      population_variance <= pvar;
      sample_variance     <= svar;
      std_deviation       <= sq_res[31:0];
      minimum             <= (rec.count != '0 && ev) ? rec.minv : '0;
      maximum             <= (rec.count != '0 && ev) ? rec.maxv : '0;
      window_average      <= wavg;
      saturated           <= (rec.count == '1) || (rec.m2 == '1);
    end
  end

`ifndef ASSERT_OFF
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == mrs_pkg::S_RD)
    else $error("accepted request did not start a record read");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == mrs_pkg::S_WDAT |-> walk < fill_r)
    else $error("window walk ran past the fill count");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == mrs_pkg::S_MDIV || state == mrs_pkg::S_PDIV ||
                  state == mrs_pkg::S_SDIV || state == mrs_pkg::S_WDIV))
    else $error("divider finished outside a divide wait");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(sample_total) && $stable(window_average))
    else $error("held result changed");

  a_fill_limit: assert property (@(posedge clk) disable iff (rst)
    state == mrs_pkg::S_WR |-> fill_r <= eff_cur)
    else $error("fill count above window size");
`endif

endmodule
